### rtl/core/mbm_pkg.sv
// ----------------------------------------------------------------------------
// mbm_pkg
// shared types and constants of the multiband band-pass mask generator
// ----------------------------------------------------------------------------
package mbm_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int BIN_W     = 16;
	localparam int N_W       = 17;
	localparam int FREQ_W    = 18;
	localparam int BETA_W    = 17;
	localparam int XW        = 50;
	localparam int DIV_STEPS = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FFT_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT  = 3'd3;
	localparam int                   REG_BAND_BASE   = 4;

	localparam logic [BETA_W-1:0] BETA_ONE  = 17'd65536;
	localparam logic [15:0]       W_ONE     = 16'h8000;
	localparam logic [30:0]       Q30_ONE   = 31'h4000_0000;
	localparam logic [31:0]       PI_Q30    = 32'd3373259426;

	// exact reciprocals for 32-bit floor division by a constant
	localparam logic [32:0] RCP_72 = 33'd7635497416;
	localparam logic [32:0] RCP_42 = 33'd6544712071;
	localparam logic [32:0] RCP_20 = 33'd6871947674;
	localparam logic [32:0] RCP_6  = 33'd5726623062;

	typedef struct packed {
		logic          box_hit;
		logic          pass;
		logic          trans;
		logic [XW-1:0] x;
		logic [XW-1:0] den;
	} mbm_lane_t;

	typedef struct packed {
		logic covered;
		logic use_cos;
	} mbm_tag_t;

endpackage

### rtl/core/mbm_lane.sv
// ----------------------------------------------------------------------------
// mbm_lane
// per-band classification: boxcar hit, passband, transition phase operands
// ----------------------------------------------------------------------------
module mbm_lane import mbm_pkg::*; (
	input  logic                     clk,
	input  logic [BIN_W-1:0]         k_s1,
	input  logic signed [FREQ_W-1:0] f_s1,
	input  logic [N_W-1:0]           n,
	input  logic [BETA_W-1:0]        beta,
	input  logic [63:0]              band,
	output mbm_lane_t                res_s4
);

	function automatic logic [N_W-1:0] edge_idx(input logic signed [34:0] v,
		input logic [N_W-1:0] lim);
		logic [34:0] r;
		logic [25:0] q;
		begin
			r = 35'(v[33:0]) + 35'd256;
			q = r[34:9];
			if (v[34])
				edge_idx = '0;
			else if (q > 26'(lim))
				edge_idx = lim;
			else
				edge_idx = q[N_W-1:0];
		end
	endfunction

	// stage a
	logic signed [31:0] ctr;
	logic [31:0]        bw;
	logic signed [33:0] diff;
	logic [32:0]        absd;
	logic [48:0]        e_a;
	logic signed [34:0] c2, bw35, off, vl, vh;

	assign ctr  = signed'(band[63:32]);
	assign bw   = band[31:0];
	assign diff = 34'(signed'({f_s1, 8'b0})) - 34'(ctr);
	assign absd = diff[33] ? 33'(-diff) : diff[32:0];
	assign e_a  = 49'(bw) * 49'(beta);
	assign c2   = signed'({ctr[31], ctr[31], ctr, 1'b0});
	assign bw35 = signed'({3'b0, bw});
	assign off  = signed'({9'b0, n, 9'b0});
	assign vl   = c2 - bw35;
	assign vh   = c2 + bw35;

	logic [32:0]        absd_s2;
	logic [48:0]        e_s2;
	logic [31:0]        bw_s2;
	logic signed [34:0] al_s2, ah_s2;
	logic               wrap_s2;
	logic [BIN_W-1:0]   k_s2;

	always_ff @(posedge clk) begin
		absd_s2 <= absd;
		e_s2    <= e_a;
		bw_s2   <= bw;
		al_s2   <= vl[34] ? vl + off : vl;
		ah_s2   <= vh[34] ? vh + off : vh;
		wrap_s2 <= vl[34] & ~vh[34];
		k_s2    <= k_s1;
	end

	// stage b
	logic [XW-1:0] d_b, h_b;
	logic [XW:0]   sum_b;

	assign d_b   = {absd_s2, 17'b0};
	assign h_b   = {2'b0, bw_s2, 16'b0};
	assign sum_b = 51'(d_b) + 51'(e_s2);

	logic             pass_s3, trans_s3, wrap_s3;
	logic [XW-1:0]    x_s3, den_s3;
	logic [N_W-1:0]   il_s3, ih_s3;
	logic [BIN_W-1:0] k_s3;

	always_ff @(posedge clk) begin
		pass_s3  <= sum_b <= 51'(h_b);
		trans_s3 <= 51'(d_b) <= 51'(h_b) + 51'(e_s2);
		x_s3     <= XW'(sum_b - 51'(h_b));
		den_s3   <= {e_s2, 1'b0};
		il_s3    <= edge_idx(al_s2, n);
		ih_s3    <= edge_idx(ah_s2, n);
		wrap_s3  <= wrap_s2;
		k_s3     <= k_s2;
	end

	// stage c
	logic ge_l, lt_h;

	assign ge_l = 17'(k_s3) >= il_s3;
	assign lt_h = 17'(k_s3) < ih_s3;

	always_ff @(posedge clk) begin
		res_s4.box_hit <= wrap_s3 ? (ge_l | lt_h) : (ge_l & lt_h);
		res_s4.pass    <= pass_s3;
		res_s4.trans   <= trans_s3;
		res_s4.x       <= x_s3;
		res_s4.den     <= den_s3;
	end

endmodule

### rtl/core/mbm_div.sv
// ----------------------------------------------------------------------------
// mbm_div
// pipelined restoring divider, one quotient bit per stage, phase rounding
// ----------------------------------------------------------------------------
module mbm_div import mbm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [XW-1:0] in_x,
	input  logic [XW-1:0] in_den,
	input  logic          in_sat,
	input  mbm_tag_t      in_tag,
	output logic          out_vld,
	output logic [16:0]   out_p,
	output mbm_tag_t      out_tag
);

	logic                 vld_s [DIV_STEPS];
	logic [XW-1:0]        rem_s [DIV_STEPS];
	logic [XW-1:0]        den_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS];
	logic                 sat_s [DIV_STEPS];
	mbm_tag_t             tag_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic                 v_in, s_in, ge;
		logic [XW-1:0]        r_in, d_in;
		logic [DIV_STEPS-1:0] q_in;
		mbm_tag_t             t_in;
		logic [XW:0]          r2;

		if (j == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = in_x;
			assign d_in = in_den;
			assign q_in = '0;
			assign s_in = in_sat;
			assign t_in = in_tag;
		end else begin : g_next
			assign v_in = vld_s[j-1];
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = quo_s[j-1];
			assign s_in = sat_s[j-1];
			assign t_in = tag_s[j-1];
		end

		assign r2 = {r_in, 1'b0};
		assign ge = r2 >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? XW'(r2 - {1'b0, d_in}) : r2[XW-1:0];
			den_s[j] <= d_in;
			quo_s[j] <= {q_in[DIV_STEPS-2:0], ge};
			sat_s[j] <= s_in;
			tag_s[j] <= t_in;
		end
	end

	logic [17:0] qr;

	assign qr      = 18'(quo_s[DIV_STEPS-1]) + 18'd1;
	assign out_vld = vld_s[DIV_STEPS-1];
	assign out_tag = tag_s[DIV_STEPS-1];
	assign out_p   = sat_s[DIV_STEPS-1] ? BETA_ONE : qr[17:1];

	// remainder stays below the divisor for every unsaturated item
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STEPS-1] && !sat_s[DIV_STEPS-1] |->
			rem_s[DIV_STEPS-1] < den_s[DIV_STEPS-1])
		else $error("divider remainder out of bound");

endmodule

### rtl/core/mbm_cos.sv
// ----------------------------------------------------------------------------
// mbm_cos
// raised-cosine weight from phase: odd sine polynomial in q30, pipelined
// ----------------------------------------------------------------------------
module mbm_cos import mbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [16:0] in_p,
	input  mbm_tag_t    in_tag,
	output logic        out_vld,
	output logic [15:0] out_weight,
	output logic        out_covered
);

	localparam int NST = 11;

	logic     vld_s [1:NST];
	logic     neg_s [1:NST-1];
	mbm_tag_t tag_s [1:NST-1];

	// stage 1: distance from the half phase, scaled by pi
	logic [15:0] a_c;
	logic [47:0] ya_c;

	assign a_c  = (in_p >= 17'd32768) ? 16'(in_p - 17'd32768) : 16'(17'd32768 - in_p);
	assign ya_c = 48'(a_c) * 48'(PI_Q30);

	logic [30:0] y_s [1:9];
	logic [31:0] y2_s2, y2_s3, y2_s4, y2_s5, y2_s6, y2_s7;
	logic [30:0] t_s3, t_s5, t_s7, t_s9;
	logic [31:0] pr_s4, pr_s6, pr_s8;
	logic [30:0] s_s10;

	logic [61:0] sq_c;
	logic [64:0] m3_c, m5_c, m7_c, m9_c;
	logic [62:0] p4_c, p6_c, p8_c;
	logic [61:0] p10_c;

	assign sq_c  = 62'(y_s[1]) * 62'(y_s[1]);
	assign m3_c  = 65'(y2_s2) * 65'(RCP_72);
	assign p4_c  = 63'(y2_s3) * 63'(t_s3);
	assign m5_c  = 65'(pr_s4) * 65'(RCP_42);
	assign p6_c  = 63'(y2_s5) * 63'(t_s5);
	assign m7_c  = 65'(pr_s6) * 65'(RCP_20);
	assign p8_c  = 63'(y2_s7) * 63'(t_s7);
	assign m9_c  = 65'(pr_s8) * 65'(RCP_6);
	assign p10_c = 62'(y_s[9]) * 62'(t_s9);

	// stage 11: saturate sine and fold into the weight
	logic [30:0] sv_c;
	logic [32:0] wsum_c;
	logic [15:0] w_c;

	assign sv_c   = (s_s10 > Q30_ONE) ? Q30_ONE : s_s10;
	assign wsum_c = neg_s[10] ? 33'(Q30_ONE) + 33'(sv_c) + 33'd32768
	                          : 33'(Q30_ONE) - 33'(sv_c) + 33'd32768;
	assign w_c    = wsum_c[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= in_vld;
			for (int i = 2; i <= NST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		neg_s[1] <= in_p < 17'd32768;
		tag_s[1] <= in_tag;
		for (int i = 2; i <= NST - 1; i++) begin
			neg_s[i] <= neg_s[i-1];
			tag_s[i] <= tag_s[i-1];
		end
		y_s[1] <= ya_c[46:16];
		for (int i = 2; i <= 9; i++) y_s[i] <= y_s[i-1];
		y2_s2 <= sq_c[61:30];
		y2_s3 <= y2_s2;
		t_s3  <= Q30_ONE - 31'(m3_c[64:39]);
		y2_s4 <= y2_s3;
		pr_s4 <= p4_c[61:30];
		y2_s5 <= y2_s4;
		t_s5  <= Q30_ONE - 31'(m5_c[64:38]);
		y2_s6 <= y2_s5;
		pr_s6 <= p6_c[61:30];
		y2_s7 <= y2_s6;
		t_s7  <= Q30_ONE - 31'(m7_c[64:37]);
		pr_s8 <= p8_c[61:30];
		t_s9  <= Q30_ONE - 31'(m9_c[64:35]);
		s_s10 <= p10_c[60:30];
		if (!tag_s[10].covered)
			out_weight <= '0;
		else if (tag_s[10].use_cos)
			out_weight <= w_c;
		else
			out_weight <= W_ONE;
		out_covered <= tag_s[10].covered;
	end

	assign out_vld = vld_s[NST];

endmodule

### rtl/core/multiband_bandpass_mask_generator.sv
// ----------------------------------------------------------------------------
// multiband_bandpass_mask_generator
// per-bin band-pass weight in q1.15, boxcar or raised-cosine over four bands
// ----------------------------------------------------------------------------
// done rises when the item taken with start leaves the cosine pipeline
// throughput: one item per cycle, start is never refused (busy stays low)
// the 17-stage phase divider and the 11-stage cosine polynomial set the depth
// the receiver cannot stall: each result shows for one cycle with done high
// reset: registers return to mode raised cosine, 1024 bins, beta 0.25, no bands
// and every item in flight is dropped
module multiband_bandpass_mask_generator import mbm_pkg::*; #(
	parameter int MAX_FFT   = 65536,
	parameter int MAX_BANDS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [BIN_W-1:0]     bin_index,
	output logic                 done,
	output logic [15:0]          weight,
	output logic                 covered,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam logic [N_W-1:0]       FftMax  = N_W'(MAX_FFT);
	localparam logic [CFG_IDX_W-1:0] BandMax = CFG_IDX_W'(MAX_BANDS);

	// configuration registers; the user must write them only while no item is in flight, the block does not enforce it
	logic              filter_mode_q;
	logic [N_W-1:0]    fft_length_q;
	logic [BETA_W-1:0] beta_q;
	logic [2:0]        band_count_q;
	logic [63:0]       band_q [MAX_BANDS];

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= 1'b1;
			fft_length_q  <= 17'd1024;
			beta_q        <= 17'd16384;
			band_count_q  <= '0;
			for (int i = 0; i < MAX_BANDS; i++) band_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FILTER_MODE: filter_mode_q <= cfg_data[0];
				REG_FFT_LENGTH:  fft_length_q  <= cfg_data[N_W-1:0];
				REG_BETA:        beta_q        <= cfg_data[BETA_W-1:0];
				REG_BAND_COUNT:  band_count_q  <= cfg_data[2:0];
				default: begin
					// band registers; indexes past the built bands are dropped
					for (int i = 0; i < MAX_BANDS; i++)
						if (cfg_index == CFG_IDX_W'(REG_BAND_BASE + i))
							band_q[i] <= cfg_data;
				end
			endcase
		end
	end

	// saturated views of the registers
	logic [N_W-1:0]    n_eff;
	logic [BETA_W-1:0] beta_eff;
	logic [2:0]        nb_eff;

	assign n_eff    = (fft_length_q == '0) ? N_W'(1) :
	                  (fft_length_q > FftMax) ? FftMax : fft_length_q;
	assign beta_eff = (beta_q > BETA_ONE) ? BETA_ONE : beta_q;
	assign nb_eff   = (band_count_q > BandMax) ? BandMax : band_count_q;

	// stage 1: signed bin frequency in fft order, upper half negative
	logic [N_W-1:0]           k17, half;
	logic signed [FREQ_W-1:0] f_c;

	assign k17  = {1'b0, bin_index};
	assign half = ((n_eff - 17'd1) >> 1) + 17'd1;
	assign f_c  = (k17 < half) ? signed'({1'b0, k17})
	                           : signed'({1'b0, k17}) - signed'({1'b0, n_eff});

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     inr_s1, inr_s2, inr_s3, inr_s4;
	logic [BIN_W-1:0]         k_s1;
	logic signed [FREQ_W-1:0] f_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		k_s1   <= bin_index;
		f_s1   <= f_c;
		inr_s1 <= k17 < n_eff;   // bins past the length give zero
		inr_s2 <= inr_s1;
		inr_s3 <= inr_s2;
		inr_s4 <= inr_s3;
	end

	// stages 2 to 4: one lane per band
	mbm_lane_t lane_s4 [MAX_BANDS];

	for (genvar i = 0; i < MAX_BANDS; i++) begin : g_lane
		mbm_lane u_lane (
			.clk    (clk),
			.k_s1   (k_s1),
			.f_s1   (f_s1),
			.n      (n_eff),
			.beta   (beta_eff),
			.band   (band_q[i]),
			.res_s4 (lane_s4[i])
		);
	end

	// stage 5: boxcar ors the bands, raised cosine keeps the last touching band
	logic          any_hit, found, spass;
	logic [XW-1:0] sx, sden;
	mbm_tag_t      tag_c;

	always_comb begin
		any_hit = 1'b0;
		found   = 1'b0;
		spass   = 1'b0;
		sx      = '0;
		sden    = '0;
		for (int i = 0; i < MAX_BANDS; i++) begin
			if (3'(i) < nb_eff) begin
				any_hit = any_hit | lane_s4[i].box_hit;
				if (lane_s4[i].pass || lane_s4[i].trans) begin
					found = 1'b1;
					spass = lane_s4[i].pass;
					sx    = lane_s4[i].x;
					sden  = lane_s4[i].den;
				end
			end
		end
		tag_c.covered = inr_s4 & (filter_mode_q ? found : any_hit);
		tag_c.use_cos = inr_s4 & filter_mode_q & found & ~spass;
	end

	mbm_tag_t      tag_s5;
	logic [XW-1:0] x_s5, den_s5;
	logic          sat_s5;

	always_ff @(posedge clk) begin
		tag_s5 <= tag_c;
		x_s5   <= sx;
		den_s5 <= sden;
		sat_s5 <= sx >= sden;   // phase reaches one, no division needed
	end

	// phase = transition offset over transition width, 16 fraction bits
	logic        v_div;
	logic [16:0] p_div;
	mbm_tag_t    tag_div;

	mbm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s5),
		.in_x    (x_s5),
		.in_den  (den_s5),
		.in_sat  (sat_s5),
		.in_tag  (tag_s5),
		.out_vld (v_div),
		.out_p   (p_div),
		.out_tag (tag_div)
	);

	// (1 + cos(pi p)) / 2 and the final weight selection
	mbm_cos u_cos (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (v_div),
		.in_p        (p_div),
		.in_tag      (tag_div),
		.out_vld     (done),
		.out_weight  (weight),
		.out_covered (covered)
	);

	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> weight <= W_ONE)
		else $error("weight above one");

	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !covered |-> weight == '0)
		else $error("uncovered bin with nonzero weight");

	a_done_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(done))
		else $error("done strobe unknown");

endmodule
